### hdl/byte_stuffed_frame_builder_assert.svh
// ----------------------------------------------------------------------------
// byte_stuffed_frame_builder assertion macros
// shared concurrent assertion forms for the framer modules
// ----------------------------------------------------------------------------
`ifndef BYTE_STUFFED_FRAME_BUILDER_ASSERT_SVH
`define BYTE_STUFFED_FRAME_BUILDER_ASSERT_SVH

// same-cycle implication
`define BSFB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsfb check failed");

// next-cycle implication
`define BSFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsfb check failed");

`endif

### hdl/bsfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfb_pkg
// types and constants shared by the byte stuffing framer
// ----------------------------------------------------------------------------
package bsfb_pkg;

    localparam logic [1:0] CFG_FLAG   = 2'd0;
    localparam logic [1:0] CFG_ESCAPE = 2'd1;
    localparam logic [1:0] CFG_MASK   = 2'd2;
    localparam logic [1:0] CFG_ADDR   = 2'd3;

    localparam logic [7:0] RST_FLAG   = 8'h7E;
    localparam logic [7:0] RST_ESCAPE = 8'h7D;
    localparam logic [7:0] RST_MASK   = 8'h20;
    localparam logic [7:0] RST_ADDR   = 8'h03;

    // output byte sequence of one word
    localparam logic [2:0] ST_OPEN  = 3'd0;
    localparam logic [2:0] ST_ADDR  = 3'd1;
    localparam logic [2:0] ST_CTRL  = 3'd2;
    localparam logic [2:0] ST_BCC1  = 3'd3;
    localparam logic [2:0] ST_ESC   = 3'd4;
    localparam logic [2:0] ST_DATA  = 3'd5;
    localparam logic [2:0] ST_BCC2  = 3'd6;
    localparam logic [2:0] ST_CLOSE = 3'd7;

    typedef struct packed {
        logic       hdr;
        logic       stuff;
        logic       last;
        logic [7:0] flag;
        logic [7:0] addr;
        logic [7:0] ctrl;
        logic [7:0] bcc1;
        logic [7:0] esc;
        logic [7:0] dbyte;
        logic [7:0] bcc2;
    } t_desc;

endpackage

### hdl/byte_stuffed_frame_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stuffed_frame_builder
// hdlc-like framer with byte stuffing and xor block checks
// ----------------------------------------------------------------------------
// Payload words enter one per cycle while the descriptor queue has room. Each
// word is classified on entry and then expanded by the output sequencer at one
// byte per cycle when not stalled: 1 byte for a plain payload byte, 2 when
// stuffed, plus 4 header bytes on the first word of a frame and 2 closing
// bytes (BCC2, flag) on the last, so a word gives 1 to 8 output bytes and the
// sustained rate is set by that single output byte lane. The queue of
// QUEUE_DEPTH words lets the input keep flowing while the output stalls or
// expands a word. Config writes take effect on the next accepted word.
module byte_stuffed_frame_builder
    import bsfb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // data_byte [7:0], ctrl_byte [15:8]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte [7:0]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // frame_end [0]
);

    t_desc w_push_desc, w_head;
    logic  w_push, w_pop, w_full, w_empty;

    bsfb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .i_data     (s_axis_tdata[7:0]),
        .i_ctrl     (s_axis_tdata[15:8]),
        .i_last     (s_axis_tlast),
        .i_full     (w_full),
        .o_ready    (s_axis_tready),
        .o_push     (w_push),
        .o_desc     (w_push_desc)
    );

    bsfb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_push_desc),
        .i_pop   (w_pop),
        .o_desc  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    bsfb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_desc   (w_head),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_tuser  (m_axis_tuser)
    );

endmodule

### hdl/bsfb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfb_front
// config registers, frame tracking and classification of payload words
// ----------------------------------------------------------------------------
module bsfb_front
    import bsfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    input  logic [7:0] i_data,
    input  logic [7:0] i_ctrl,
    input  logic       i_last,
    input  logic       i_full,
    output logic       o_ready,
    output logic       o_push,
    output t_desc      o_desc
);

    logic [7:0] r_flag, r_esc, r_mask, r_addr;
    logic       r_in_frame, n_in_frame;
    logic [7:0] r_check, n_check;
    logic [7:0] w_bcc2;
    logic       w_hdr;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign w_hdr   = !r_in_frame;
    assign w_bcc2  = w_hdr ? i_data : (r_check ^ i_data);

    always_comb begin
        o_desc       = '0;
        o_desc.hdr   = w_hdr;
        o_desc.stuff = (i_data == r_flag) || (i_data == r_esc);
        o_desc.last  = i_last;
        o_desc.flag  = r_flag;
        o_desc.addr  = r_addr;
        o_desc.ctrl  = i_ctrl;
        o_desc.bcc1  = r_addr ^ i_ctrl;
        o_desc.esc   = r_esc;
        o_desc.dbyte = o_desc.stuff ? (i_data ^ r_mask) : i_data;
        o_desc.bcc2  = w_bcc2;
    end

    always_comb begin
        n_in_frame = r_in_frame;
        n_check    = r_check;
        if (o_push) begin
            n_in_frame = !i_last;
            n_check    = i_last ? 8'd0 : w_bcc2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag     <= RST_FLAG;
            r_esc      <= RST_ESCAPE;
            r_mask     <= RST_MASK;
            r_addr     <= RST_ADDR;
            r_in_frame <= 1'b0;
            r_check    <= 8'd0;
        end else begin
            r_in_frame <= n_in_frame;
            r_check    <= n_check;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FLAG:   r_flag <= i_cfg_data;
                    CFG_ESCAPE: r_esc  <= i_cfg_data;
                    CFG_MASK:   r_mask <= i_cfg_data;
                    CFG_ADDR:   r_addr <= i_cfg_data;
                    default:    r_flag <= r_flag;
                endcase
            end
        end
    end

endmodule

### hdl/bsfb_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfb_fifo
// short descriptor queue between front and back
// ----------------------------------------------------------------------------
module bsfb_fifo
    import bsfb_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    input  logic  i_pop,
    output t_desc o_desc,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_desc         r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_desc  = r_mem[r_rd];

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`include "byte_stuffed_frame_builder_assert.svh"

    `BSFB_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
    `BSFB_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty)
    `BSFB_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))

endmodule

### hdl/bsfb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfb_back
// walks each descriptor and drives one framed byte per cycle when not stalled
// ----------------------------------------------------------------------------
module bsfb_back
    import bsfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_desc      i_desc,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_tdata,
    output logic       o_tlast,
    output logic       o_tuser
);

    logic       r_mid;
    logic [2:0] r_step;
    logic       r_tvalid;
    logic [7:0] r_tdata;
    logic       r_tlast, r_tuser;
    logic [2:0] w_cur, w_next, w_start;
    logic [7:0] w_byte;
    logic       w_done, w_load;

    assign w_start = i_desc.hdr ? ST_OPEN : (i_desc.stuff ? ST_ESC : ST_DATA);
    assign w_cur   = r_mid ? r_step : w_start;
    assign w_load  = !i_empty && (!r_tvalid || i_tready);
    assign w_done  = ((w_cur == ST_DATA) && !i_desc.last) || (w_cur == ST_CLOSE);
    assign o_pop   = w_load && w_done;

    always_comb begin
        case (w_cur)
            ST_OPEN:  begin w_byte = i_desc.flag;  w_next = ST_ADDR; end
            ST_ADDR:  begin w_byte = i_desc.addr;  w_next = ST_CTRL; end
            ST_CTRL:  begin w_byte = i_desc.ctrl;  w_next = ST_BCC1; end
            ST_BCC1:  begin
                w_byte = i_desc.bcc1;
                w_next = i_desc.stuff ? ST_ESC : ST_DATA;
            end
            ST_ESC:   begin w_byte = i_desc.esc;   w_next = ST_DATA; end
            ST_DATA:  begin w_byte = i_desc.dbyte; w_next = ST_BCC2; end
            ST_BCC2:  begin w_byte = i_desc.bcc2;  w_next = ST_CLOSE; end
            ST_CLOSE: begin w_byte = i_desc.flag;  w_next = ST_OPEN; end
            default:  begin w_byte = i_desc.flag;  w_next = ST_OPEN; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_tdata <= w_byte;
            r_tlast <= w_done;
            r_tuser <= (w_cur == ST_CLOSE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid    <= 1'b0;
            r_step   <= ST_OPEN;
            r_tvalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_tvalid <= 1'b1;
                r_mid    <= !w_done;
                r_step   <= w_next;
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;
    assign o_tuser  = r_tuser;

`include "byte_stuffed_frame_builder_assert.svh"

    `BSFB_ASSERT_NOW(a_end_is_last, i_clk, i_rst_n, r_tvalid && r_tuser, r_tlast)
    `BSFB_ASSERT_NOW(a_mid_has_desc, i_clk, i_rst_n, r_mid, !i_empty)
    `BSFB_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_load, r_tvalid)

endmodule
